@@ hw/rtl/hkse_pkg.sv @@
// ----------------------------------------------------------------------------
// hkse_pkg: shared types, constants and translation table
// Holds the controller state type, command/status structs and the usage to
// set-1 scan code lookup used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package hkse_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int TIME_WIDTH = 32;
   localparam int FIRST_SLOT = 2;
   localparam int SLOT_IDX_W = 4;
   localparam logic [7:0] MOD_BASE = 8'hE0;
   localparam logic [15:0] REPEAT_DELAY_RESET = 16'd200;

   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_NAK    = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REL_CHECK,
      ST_REL_EMIT,
      ST_PRS_READ,
      ST_PRS_CHECK,
      ST_PRS_EMIT
   } state_type;

   typedef struct packed {
      logic load_report;  // shift slots, capture new report
      logic tick;         // advance millisecond count
      logic clr_idx;      // reset slot walker to first slot
      logic adv_idx;      // advance slot walker
      logic rel_apply;    // clear held mark of previous slot code
      logic prs_apply;    // set held mark, stamp time
      logic rd_time;      // issue time memory read for current slot
      logic out_load;     // load output word
      logic out_release;
   } cmd_type;

   typedef struct packed {
      logic idx_end;      // walker on last slot
      logic rel_hit;      // previous slot code vanished and known
      logic prs_hit;      // current slot code gives a press
      logic out_full;     // output word waiting
   } sts_type;

   // Returns {known, extended, scan}
   function automatic logic [9:0] lookup(input logic [7:0] code);
      logic [15:0] e;
      logic k;
      k = 1'b1;
      e = 16'h0000;
      case (code)
         8'h04: e = 16'h1E; 8'h05: e = 16'h30; 8'h06: e = 16'h2E; 8'h07: e = 16'h20;
         8'h08: e = 16'h12; 8'h09: e = 16'h21; 8'h0A: e = 16'h22; 8'h0B: e = 16'h23;
         8'h0C: e = 16'h17; 8'h0D: e = 16'h24; 8'h0E: e = 16'h25; 8'h0F: e = 16'h26;
         8'h10: e = 16'h32; 8'h11: e = 16'h31; 8'h12: e = 16'h18; 8'h13: e = 16'h19;
         8'h14: e = 16'h10; 8'h15: e = 16'h13; 8'h16: e = 16'h1F; 8'h17: e = 16'h14;
         8'h18: e = 16'h16; 8'h19: e = 16'h2F; 8'h1A: e = 16'h11; 8'h1B: e = 16'h2D;
         8'h1C: e = 16'h15; 8'h1D: e = 16'h2C; 8'h1E: e = 16'h02; 8'h1F: e = 16'h03;
         8'h20: e = 16'h04; 8'h21: e = 16'h05; 8'h22: e = 16'h06; 8'h23: e = 16'h07;
         8'h24: e = 16'h08; 8'h25: e = 16'h09; 8'h26: e = 16'h0A; 8'h27: e = 16'h0B;
         8'h28: e = 16'h1C; 8'h29: e = 16'h01; 8'h2A: e = 16'h0E; 8'h2B: e = 16'h0F;
         8'h2C: e = 16'h39; 8'h2D: e = 16'h0C; 8'h2E: e = 16'h0D; 8'h2F: e = 16'h1A;
         8'h30: e = 16'h1B; 8'h31: e = 16'h2B; 8'h32: e = 16'h2B; 8'h33: e = 16'h27;
         8'h34: e = 16'h28; 8'h35: e = 16'h29; 8'h36: e = 16'h33; 8'h37: e = 16'h34;
         8'h38: e = 16'h35; 8'h39: e = 16'h3A; 8'h3A: e = 16'h3B; 8'h3B: e = 16'h3C;
         8'h3C: e = 16'h3D; 8'h3D: e = 16'h3E; 8'h3E: e = 16'h3F; 8'h3F: e = 16'h40;
         8'h40: e = 16'h41; 8'h41: e = 16'h42; 8'h42: e = 16'h43; 8'h43: e = 16'h44;
         8'h44: e = 16'h57; 8'h45: e = 16'h58; 8'h46: e = 16'hE037; 8'h47: e = 16'h46;
         8'h48: e = 16'hE046; 8'h49: e = 16'hE052; 8'h4A: e = 16'hE047;
         8'h4B: e = 16'hE049; 8'h4C: e = 16'hE053; 8'h4D: e = 16'hE04F;
         8'h4E: e = 16'hE051; 8'h4F: e = 16'hE04D; 8'h50: e = 16'hE04B;
         8'h51: e = 16'hE050; 8'h52: e = 16'hE048; 8'h53: e = 16'h45;
         8'h54: e = 16'hE035; 8'h55: e = 16'h37; 8'h56: e = 16'h4A; 8'h57: e = 16'h4E;
         8'h58: e = 16'hE01C; 8'h59: e = 16'h4F; 8'h5A: e = 16'h50; 8'h5B: e = 16'h51;
         8'h5C: e = 16'h4B; 8'h5D: e = 16'h4C; 8'h5E: e = 16'h4D; 8'h5F: e = 16'h47;
         8'h60: e = 16'h48; 8'h61: e = 16'h49; 8'h62: e = 16'h52; 8'h63: e = 16'h53;
         8'h64: e = 16'h56; 8'h65: e = 16'hE05D; 8'h66: e = 16'hE05E; 8'h67: e = 16'h59;
         8'h68: e = 16'h64; 8'h69: e = 16'h65; 8'h6A: e = 16'h66; 8'h6B: e = 16'h67;
         8'h6C: e = 16'h68; 8'h6D: e = 16'h69; 8'h6E: e = 16'h6A; 8'h6F: e = 16'h6B;
         8'h70: e = 16'h6C; 8'h71: e = 16'h6D; 8'h72: e = 16'h6E; 8'h73: e = 16'h76;
         8'hE0: e = 16'h1D; 8'hE1: e = 16'h2A; 8'hE2: e = 16'h38; 8'hE3: e = 16'hE05B;
         8'hE4: e = 16'hE01D; 8'hE5: e = 16'h36; 8'hE6: e = 16'hE038;
         8'hE7: e = 16'hE05C;
         default: k = 1'b0;
      endcase
      return {k, (e[15:8] != 8'h00), e[7:0]};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hkse_datapath.sv @@
// ----------------------------------------------------------------------------
// hkse_datapath: slot store, held marks, time stamps and output word
// Evaluates one slot per step under controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
module hkse_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hkse_pkg::cmd_type   cmd,
   output hkse_pkg::sts_type        sts,
   input  wire logic [7:0]          in_mods,
   input  wire logic [7:0]          in_k0,
   input  wire logic [7:0]          in_k1,
   input  wire logic [7:0]          in_k2,
   input  wire logic [7:0]          in_k3,
   input  wire logic [7:0]          in_k4,
   input  wire logic [7:0]          in_k5,
   input  wire logic [15:0]         delay,
   input  wire logic                out_take,
   output logic [7:0]               out_usage,
   output logic [7:0]               out_scan,
   output logic                     out_ext,
   output logic                     out_rel
);
   localparam int N = hkse_pkg::SLOT_COUNT;
   localparam int TW = hkse_pkg::TIME_WIDTH;

   logic [7:0] prev_ff [N];
   logic [7:0] cur_ff  [N];
   logic [255:0] held_ff;
   logic [TW-1:0] stamp_mem [256];
   logic [TW-1:0] stamp_rd_ff;
   logic [TW-1:0] ms_ff;
   logic [hkse_pkg::SLOT_IDX_W-1:0] idx_ff;
   logic full_ff;
   logic [7:0] usage_ff, scan_ff;
   logic ext_ff, rel_ff;

   logic [7:0] pcode, ccode;
   logic [9:0] plk, clk_lk;
   logic found;
   logic [TW-1:0] elapsed;

   assign pcode = prev_ff[idx_ff];
   assign ccode = cur_ff[idx_ff];
   assign plk = hkse_pkg::lookup(pcode);
   assign clk_lk = hkse_pkg::lookup(ccode);
   assign elapsed = ms_ff - stamp_rd_ff;

   always_comb begin
      found = 1'b0;
      for (int q = hkse_pkg::FIRST_SLOT; q < N; q++) begin
         if (cur_ff[q] == pcode) found = 1'b1;
      end
   end

   always_comb begin
      sts = '0;
      sts.idx_end = (idx_ff == hkse_pkg::SLOT_IDX_W'(N - 1));
      sts.rel_hit = !found && plk[9];
      sts.prs_hit = clk_lk[9] && (!held_ff[ccode] ||
                    ((ccode < hkse_pkg::MOD_BASE) && (elapsed > TW'(delay))));
      sts.out_full = full_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_time) stamp_rd_ff <= stamp_mem[ccode];
      if (cmd.prs_apply && !held_ff[ccode]) stamp_mem[ccode] <= ms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            prev_ff[i] <= 8'h00;
            cur_ff[i]  <= 8'h00;
         end
         held_ff <= '0;
         ms_ff   <= '0;
         idx_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         if (cmd.tick) ms_ff <= ms_ff + TW'(1);
         if (cmd.load_report) begin
            for (int i = 0; i < N; i++) prev_ff[i] <= cur_ff[i];
            cur_ff[0] <= in_mods;
            cur_ff[1] <= 8'h00;
            cur_ff[2] <= in_k0;
            cur_ff[3] <= in_k1;
            cur_ff[4] <= in_k2;
            cur_ff[5] <= in_k3;
            cur_ff[6] <= in_k4;
            cur_ff[7] <= in_k5;
            for (int i = 0; i < 8; i++)
               cur_ff[8 + i] <= in_mods[i] ? (hkse_pkg::MOD_BASE | 8'(i)) : 8'h00;
         end
         if (cmd.clr_idx) idx_ff <= hkse_pkg::SLOT_IDX_W'(hkse_pkg::FIRST_SLOT);
         else if (cmd.adv_idx) idx_ff <= idx_ff + 1'b1;
         if (cmd.rel_apply) held_ff[pcode] <= 1'b0;
         if (cmd.prs_apply) held_ff[ccode] <= 1'b1;
         if (cmd.out_load) full_ff <= 1'b1;
         else if (out_take) full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         usage_ff <= cmd.out_release ? pcode : ccode;
         scan_ff  <= cmd.out_release ? plk[7:0] : clk_lk[7:0];
         ext_ff   <= cmd.out_release ? plk[8] : clk_lk[8];
         rel_ff   <= cmd.out_release;
      end
   end

   assign out_usage = usage_ff;
   assign out_scan  = scan_ff;
   assign out_ext   = ext_ff;
   assign out_rel   = rel_ff;
endmodule
`default_nettype wire

@@ hw/rtl/hkse_controller.sv @@
// ----------------------------------------------------------------------------
// hkse_controller: pass sequencer
// Walks release then press passes (press only for a NAK), one slot per
// check, holding each event until the previous word has left.
// ----------------------------------------------------------------------------
`default_nettype none
module hkse_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_go,
   input  wire logic [1:0]         req_op,
   output logic                    req_ready,
   input  wire hkse_pkg::sts_type  sts,
   output hkse_pkg::cmd_type       cmd,
   output logic                    out_valid
);
   hkse_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == hkse_pkg::ST_IDLE) && !sts.out_full;
   assign out_valid = sts.out_full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hkse_pkg::ST_IDLE: begin
            if (req_go && (req_op == hkse_pkg::OP_REPORT))
               state_in = hkse_pkg::ST_REL_CHECK;
            else if (req_go && (req_op == hkse_pkg::OP_NAK))
               state_in = hkse_pkg::ST_PRS_READ;
         end
         hkse_pkg::ST_REL_CHECK: begin
            if (sts.rel_hit) state_in = hkse_pkg::ST_REL_EMIT;
            else if (sts.idx_end) state_in = hkse_pkg::ST_PRS_READ;
         end
         hkse_pkg::ST_REL_EMIT: begin
            if (!sts.out_full)
               state_in = sts.idx_end ? hkse_pkg::ST_PRS_READ : hkse_pkg::ST_REL_CHECK;
         end
         hkse_pkg::ST_PRS_READ: state_in = hkse_pkg::ST_PRS_CHECK;
         hkse_pkg::ST_PRS_CHECK: begin
            if (sts.prs_hit) state_in = hkse_pkg::ST_PRS_EMIT;
            else if (sts.idx_end) state_in = hkse_pkg::ST_IDLE;
            else state_in = hkse_pkg::ST_PRS_READ;
         end
         hkse_pkg::ST_PRS_EMIT: begin
            if (!sts.out_full)
               state_in = sts.idx_end ? hkse_pkg::ST_IDLE : hkse_pkg::ST_PRS_READ;
         end
         default: state_in = hkse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         hkse_pkg::ST_IDLE: begin
            cmd.clr_idx = 1'b1;
            cmd.load_report = req_go && (req_op == hkse_pkg::OP_REPORT);
            cmd.tick = req_go && (req_op == hkse_pkg::OP_TICK);
         end
         hkse_pkg::ST_REL_CHECK: begin
            if (!sts.rel_hit) begin
               if (sts.idx_end) cmd.clr_idx = 1'b1;
               else cmd.adv_idx = 1'b1;
            end
         end
         hkse_pkg::ST_REL_EMIT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               cmd.out_release = 1'b1;
               cmd.rel_apply = 1'b1;
               if (sts.idx_end) cmd.clr_idx = 1'b1;
               else cmd.adv_idx = 1'b1;
            end
         end
         hkse_pkg::ST_PRS_READ: cmd.rd_time = 1'b1;
         hkse_pkg::ST_PRS_CHECK: begin
            if (!sts.prs_hit && !sts.idx_end) cmd.adv_idx = 1'b1;
         end
         hkse_pkg::ST_PRS_EMIT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               cmd.prs_apply = 1'b1;
               if (!sts.idx_end) cmd.adv_idx = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/hid_keyboard_report_to_scancode_events_unit.sv @@
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_scancode_events_unit: boot report to set-1 events
// Converts keyboard polls and millisecond ticks into press/release words.
// ----------------------------------------------------------------------------
// channel | ports                 | direction | handshake
// req     | req_*                 | in        | valid / stall
// rsp     | rsp_*                 | out       | valid / stall
// csr     | csr_*                 | in        | valid / ready
//
// A report is accepted, then walked in a release pass (one check per slot,
// one emit step more per release) and a press pass (a time memory read and
// a check per slot, one emit step more per press). A NAK runs the press
// pass alone; a tick or an unused opcode ends on acceptance. The final word
// of an item leaves the hold stage with last set. Reset is synchronous and
// clears slots, held marks and the time count. A stalled rsp word holds the
// walker; req stalls until the walk is done and the final word has gone.
// ----------------------------------------------------------------------------
`default_nettype none
module hid_keyboard_report_to_scancode_events_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_modifier_bits,
   input  wire logic [7:0]  req_key_code_0,
   input  wire logic [7:0]  req_key_code_1,
   input  wire logic [7:0]  req_key_code_2,
   input  wire logic [7:0]  req_key_code_3,
   input  wire logic [7:0]  req_key_code_4,
   input  wire logic [7:0]  req_key_code_5,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_usage_code,
   output logic [7:0]       rsp_scan_code,
   output logic             rsp_extended,
   output logic             rsp_is_release,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   hkse_pkg::cmd_type cmd;
   hkse_pkg::sts_type sts;
   logic ready;
   logic go;
   logic [15:0] delay_ff;
   logic take;
   logic raw_valid;
   // stage buffer: hold one word back so last can be marked on the final one
   logic hold_ff;
   logic [7:0] h_usage_ff, h_scan_ff;
   logic h_ext_ff, h_rel_ff;
   logic [7:0] d_usage, d_scan;
   logic d_ext, d_rel;

   // Hold off the next item until the final word of this one has left.
   assign req_stall = !ready || hold_ff;
   assign go = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) delay_ff <= hkse_pkg::REPEAT_DELAY_RESET;
      else if (csr_valid) delay_ff <= csr_data;
   end

   hkse_controller u_ctl (
      .clock(clock), .reset(reset), .req_go(go), .req_op(req_opcode),
      .req_ready(ready), .sts(sts), .cmd(cmd), .out_valid(raw_valid)
   );

   hkse_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_mods(req_modifier_bits), .in_k0(req_key_code_0), .in_k1(req_key_code_1),
      .in_k2(req_key_code_2), .in_k3(req_key_code_3), .in_k4(req_key_code_4),
      .in_k5(req_key_code_5), .delay(delay_ff), .out_take(take),
      .out_usage(d_usage), .out_scan(d_scan), .out_ext(d_ext), .out_rel(d_rel)
   );

   // Advance a word into the hold stage when it is empty or draining to rsp.
   // When the walk is over (controller ready, no raw word), the held word is
   // the final one of its item and goes out with last set.
   assign take = raw_valid && (!hold_ff || (rsp_valid && !rsp_stall));
   assign rsp_valid = hold_ff && (raw_valid || ready);
   assign rsp_last = !raw_valid && ready;
   assign rsp_usage_code = h_usage_ff;
   assign rsp_scan_code  = h_scan_ff;
   assign rsp_extended   = h_ext_ff;
   assign rsp_is_release = h_rel_ff;

   always_ff @(posedge clock) begin
      if (reset) hold_ff <= 1'b0;
      else if (take) hold_ff <= 1'b1;
      else if (rsp_valid && !rsp_stall) hold_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         h_usage_ff <= d_usage;
         h_scan_ff  <= d_scan;
         h_ext_ff   <= d_ext;
         h_rel_ff   <= d_rel;
      end
   end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: keyboard report to scan code event unit
// Drives reports, NAK polls and millisecond ticks with random gaps, predicts
// the press/release words from a behavioral copy of the translator and checks
// every word in order against the block's output.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] mods;
      logic [7:0] k0, k1, k2, k3, k4, k5;
   } poll_word_type;

   typedef struct packed {
      logic [7:0] usage;
      logic [7:0] scan;
      logic       ext;
      logic       rel;
      logic       last;
   } key_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_stall;
   poll_word_type req_word = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_usage_code, rsp_scan_code;
   logic       rsp_extended, rsp_is_release, rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [15:0] csr_data = '0;

   // translator state held by the predictor
   logic [15:0] delay_ms;
   logic [7:0]  prev_codes [16];
   logic [7:0]  cur_codes [16];
   logic        held [256];
   logic [31:0] pressed_at [256];
   logic [31:0] ms_now;

   poll_word_type pending_polls [$];
   key_event_type expected_events [$];
   int         mismatches = 0;
   bit         hold_sender = 1'b0;
   int         send_gap = 0;
   int         sink_gap = 0;

   hid_keyboard_report_to_scancode_events_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_word.opcode), .req_modifier_bits(req_word.mods),
      .req_key_code_0(req_word.k0), .req_key_code_1(req_word.k1),
      .req_key_code_2(req_word.k2), .req_key_code_3(req_word.k3),
      .req_key_code_4(req_word.k4), .req_key_code_5(req_word.k5),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_usage_code(rsp_usage_code), .rsp_scan_code(rsp_scan_code),
      .rsp_extended(rsp_extended), .rsp_is_release(rsp_is_release),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Translation table written out independently: {known, scan entry}.
   function automatic logic [16:0] scan_entry(input logic [7:0] code);
      logic [7:0] base_scan [8'h04:8'h73];
      logic [15:0] mod_scan [8];
      base_scan = '{
         8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22,8'h23,8'h17,8'h24,8'h25,8'h26,
         8'h32,8'h31,8'h18,8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11,8'h2D,
         8'h15,8'h2C,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h0B,
         8'h1C,8'h01,8'h0E,8'h0F,8'h39,8'h0C,8'h0D,8'h1A,8'h1B,8'h2B,8'h2B,8'h27,
         8'h28,8'h29,8'h33,8'h34,8'h35,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,
         8'h41,8'h42,8'h43,8'h44,8'h57,8'h58,8'h37,8'h46,8'h46,8'h52,8'h47,8'h49,
         8'h53,8'h4F,8'h51,8'h4D,8'h4B,8'h50,8'h48,8'h45,8'h35,8'h37,8'h4A,8'h4E,
         8'h1C,8'h4F,8'h50,8'h51,8'h4B,8'h4C,8'h4D,8'h47,8'h48,8'h49,8'h52,8'h53,
         8'h56,8'h5D,8'h5E,8'h59,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h6B,
         8'h6C,8'h6D,8'h6E,8'h76};
      mod_scan = '{16'h1D,16'h2A,16'h38,16'hE05B,16'hE01D,16'h36,16'hE038,16'hE05C};
      if (code >= 8'hE0 && code <= 8'hE7) return {1'b1, mod_scan[code[2:0]]};
      if (code < 8'h04 || code > 8'h73) return '0;
      // extended entries in the main range; the duplicated code takes its first entry
      if ((code >= 8'h48 && code <= 8'h52) || code == 8'h46 || code == 8'h54 ||
          code == 8'h58 || code == 8'h65 || code == 8'h66)
         return {1'b1, 8'hE0, base_scan[code]};
      return {1'b1, 8'h00, base_scan[code]};
   endfunction

   function automatic key_event_type make_event(input logic [7:0] code, input logic rel);
      logic [16:0] e;
      key_event_type ev;
      e = scan_entry(code);
      ev.usage = code;
      ev.scan = e[7:0];
      ev.ext = (e[15:8] != 8'h00);
      ev.rel = rel;
      ev.last = 1'b0;
      return ev;
   endfunction

   // Advance the predictor by one accepted poll word; queue its events.
   task automatic predict_events(input poll_word_type w);
      key_event_type evs [$];
      logic [7:0] code;
      logic [16:0] e;
      bit found;
      if (w.opcode == hkse_pkg::OP_TICK) begin
         ms_now = ms_now + 32'd1;
         return;
      end
      if (w.opcode == OP_UNUSED) return;
      if (w.opcode == hkse_pkg::OP_REPORT) begin
         prev_codes = cur_codes;
         cur_codes[0] = w.mods;
         cur_codes[1] = 8'h00;
         cur_codes[2] = w.k0; cur_codes[3] = w.k1; cur_codes[4] = w.k2;
         cur_codes[5] = w.k3; cur_codes[6] = w.k4; cur_codes[7] = w.k5;
         for (int i = 0; i < 8; i++)
            cur_codes[8 + i] = w.mods[i] ? (hkse_pkg::MOD_BASE + 8'(i)) : 8'h00;
         // release walk: vanished known codes
         for (int k = hkse_pkg::FIRST_SLOT; k < 16; k++) begin
            code = prev_codes[k];
            found = 1'b0;
            for (int q = hkse_pkg::FIRST_SLOT; q < 16; q++)
               if (cur_codes[q] == code) found = 1'b1;
            e = scan_entry(code);
            if (!found && e[16]) begin
               held[code] = 1'b0;
               evs.push_back(make_event(code, 1'b1));
            end
         end
      end
      // press walk: new presses and repeats past the delay
      for (int k = hkse_pkg::FIRST_SLOT; k < 16; k++) begin
         code = cur_codes[k];
         e = scan_entry(code);
         if (code == 8'h00 || !e[16]) continue;
         if (!held[code]) begin
            held[code] = 1'b1;
            pressed_at[code] = ms_now;
            evs.push_back(make_event(code, 1'b0));
         end else if (code < hkse_pkg::MOD_BASE &&
                      (ms_now - pressed_at[code]) > 32'(delay_ms))
            evs.push_back(make_event(code, 1'b0));
      end
      if (evs.size() > 0) evs[$].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   // Driver: hold the word while stalled, advance on acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_events(req_word);
            void'(pending_polls.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!hold_sender && pending_polls.size() > 0) begin
            req_valid <= 1'b1;
            req_word <= pending_polls[0];
            if ($urandom_range(0, 3) == 0)
               send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 3);
         end else
            req_valid <= 1'b0;
      end
   end

   // Monitor: compare each word with the oldest expectation, randomly stall.
   always @(posedge clock) begin
      key_event_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_usage_code, rsp_scan_code, rsp_extended, rsp_is_release, rsp_last};
            if (expected_events.size() == 0) begin
               mismatches++;
               $display("%0t: expected no word, actual %h", $realtime, got);
            end else begin
               want = expected_events.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected %h %h %b %b %b, actual %h %h %b %b %b",
                           $realtime, want.usage, want.scan, want.ext, want.rel, want.last,
                           got.usage, got.scan, got.ext, got.rel, got.last);
               end
            end
         end
         if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            sink_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   function automatic poll_word_type report(input logic [7:0] m, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] c,
                                            input logic [7:0] d, input logic [7:0] e,
                                            input logic [7:0] f);
      return '{hkse_pkg::OP_REPORT, m, a, b, c, d, e, f};
   endfunction

   function automatic logic [7:0] rand_code();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 8'($urandom_range(8'h04, 8'h73));
      if (r < 8) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // Wait for the queue to drain, then idle through any trailing walk.
   task automatic drain_block();
      while (pending_polls.size() > 0 || req_valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_delay(input logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      delay_ms = v;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) pending_polls.push_back('{hkse_pkg::OP_TICK, 8'h00, 8'h0, 8'h0, 8'h0,
                                           8'h0, 8'h0, 8'h0});
   endtask

   task automatic queue_random(input int n);
      poll_word_type w;
      int r;
      repeat (n) begin
         r = $urandom_range(0, 19);
         w = '{hkse_pkg::OP_REPORT, 8'($urandom_range(0, 255)), rand_code(), rand_code(),
               rand_code(), rand_code(), rand_code(), rand_code()};
         if ($urandom_range(0, 1)) w.mods = 8'h00;
         if (r < 7) w.opcode = hkse_pkg::OP_TICK;
         else if (r < 10) w.opcode = hkse_pkg::OP_NAK;
         else if (r == 10) w.opcode = OP_UNUSED;
         pending_polls.push_back(w);
      end
   endtask

   initial begin
      delay_ms = hkse_pkg::REPEAT_DELAY_RESET;
      ms_now = '0;
      foreach (prev_codes[i]) begin prev_codes[i] = '0; cur_codes[i] = '0; end
      foreach (held[i]) begin held[i] = 1'b0; pressed_at[i] = '0; end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: every modifier, extremes, duplicate entry, repeats in a report
      write_delay(16'd0);
      pending_polls.push_back(report(8'hFF, 8'h04, 8'h73, 8'h48, 8'h00, 8'hFF, 8'h03));
      pending_polls.push_back(report(8'h00, 8'h48, 8'h48, 8'h46, 8'h54, 8'h00, 8'h00));
      queue_ticks(1);
      pending_polls.push_back('{hkse_pkg::OP_NAK, 8'h00, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                8'h0});
      pending_polls.push_back('{OP_UNUSED, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
      pending_polls.push_back(report(8'h55, 8'hE3, 8'hE0, 8'h29, 8'h29, 8'h00, 8'h00));
      pending_polls.push_back(report(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_polls.push_back(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // wait until every poll is sent and every word has arrived
      drain_block();
      write_delay(16'd2);
      pending_polls.push_back(report(8'h01, 8'h1E, 8'h58, 8'h65, 8'hE7, 8'h00, 8'h00));
      queue_ticks(2);
      pending_polls.push_back('{hkse_pkg::OP_NAK, 8'h00, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                8'h0});
      queue_ticks(1);
      pending_polls.push_back('{hkse_pkg::OP_NAK, 8'h00, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                8'h0});
      pending_polls.push_back(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_block();

      // random phases across delay settings, extremes included
      write_delay(16'd3);
      queue_random(120);
      drain_block();
      write_delay(16'hFFFF);
      queue_random(80);
      drain_block();
      write_delay(16'(($urandom_range(0, 5))));
      hold_sender = 1'b1;
      queue_random(130);
      hold_sender = 1'b0;
      drain_block();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #50000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
